FILE: src/ertm_pkg.sv
// Shared types and codes for the event replay trigger matcher.
package ertm_pkg;

    localparam logic [3:0] K_LOAD_REC   = 4'd0;
    localparam logic [3:0] K_LOAD_START = 4'd1;
    localparam logic [3:0] K_LOAD_SITE  = 4'd2;
    localparam logic [3:0] K_BEGIN      = 4'd3;
    localparam logic [3:0] K_ENTRY      = 4'd4;
    localparam logic [3:0] K_SITE_EVENT = 4'd5;
    localparam logic [3:0] K_CLOSE      = 4'd6;
    localparam logic [3:0] K_ENTER      = 4'd7;
    localparam logic [3:0] K_LEAVE      = 4'd8;
    localparam logic [3:0] K_RESTART    = 4'd9;

    localparam logic CFG_INTERVAL_COUNT = 1'b0;
    localparam logic CFG_SITE_COUNT     = 1'b1;

    localparam int HASH_SHIFT_A = 4;
    localparam int HASH_SHIFT_B = 13;
    localparam int HASH_BITS    = 28;
    localparam logic [11:0] NO_INTERVAL = 12'hFFF;
    localparam logic [7:0]  CTX_MAX     = 8'hFF;

    typedef struct packed {
        logic [15:0] site;
        logic [31:0] nth;
        logic [7:0]  kind;
        logic [15:0] ordinal;
        logic [31:0] value;
    } t_rec;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] count;
    } t_slot;

    typedef struct packed {
        logic [3:0]  tag;
        logic [31:0] key;
    } t_stab;

    typedef struct packed {
        logic latch;
        logic do_write;
        logic do_simple;
        logic hit_site;
        logic restart;
        logic clr_begin;
        logic clr_step;
        logic beg_set;
        logic start_rd0;
        logic start_rd1;
        logic cap_cursor;
        logic cap_run_end;
        logic mod_step;
        logic hash_rd;
        logic hash_chk;
        logic rec_rd;
        logic stab_rd;
        logic emit_rec;
        logic emit_status;
    } t_cmd;

    typedef struct packed {
        logic [3:0] kind;
        logic       track_on;
        logic       ctx_zero;
        logic       run_open;
        logic       site_ok;
        logic       beg_empty;
        logic       clr_last;
        logic       mod_done;
        logic       hash_resolved;
        logic       can_deliver;
        logic       rec_ok;
        logic       site_match;
    } t_stat;

endpackage

FILE: src/ertm_ctrl.sv
// Sequencer for the trigger matcher: decodes each command and walks the datapath.
module ertm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ertm_pkg::t_stat i_stat,
    output ertm_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CLR    = 4'd2;
    localparam logic [3:0] S_BEG    = 4'd3;
    localparam logic [3:0] S_BEG1   = 4'd4;
    localparam logic [3:0] S_BEG2   = 4'd5;
    localparam logic [3:0] S_MOD    = 4'd6;
    localparam logic [3:0] S_HASH_A = 4'd7;
    localparam logic [3:0] S_HASH_B = 4'd8;
    localparam logic [3:0] S_DLV    = 4'd9;
    localparam logic [3:0] S_DLV_R  = 4'd10;
    localparam logic [3:0] S_DLV_S  = 4'd11;
    localparam logic [3:0] S_STATUS = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_init, n_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_STATUS;
                unique case (i_stat.kind)
                    ertm_pkg::K_LOAD_REC, ertm_pkg::K_LOAD_START,
                    ertm_pkg::K_LOAD_SITE: begin
                        o_cmd.do_write = 1'b1;
                    end
                    ertm_pkg::K_BEGIN: begin
                        if (i_stat.track_on) begin
                            o_cmd.clr_begin = 1'b1;
                            n_state = S_CLR;
                        end
                    end
                    ertm_pkg::K_RESTART: begin
                        o_cmd.restart   = 1'b1;
                        o_cmd.clr_begin = 1'b1;
                        n_state = S_CLR;
                    end
                    ertm_pkg::K_ENTRY: begin
                        if (i_stat.track_on && i_stat.ctx_zero && i_stat.run_open)
                            n_state = S_MOD;
                    end
                    ertm_pkg::K_SITE_EVENT: begin
                        if (i_stat.track_on && i_stat.ctx_zero && i_stat.site_ok) begin
                            o_cmd.hit_site = 1'b1;
                            if (i_stat.run_open)
                                n_state = S_DLV;
                        end
                    end
                    ertm_pkg::K_CLOSE, ertm_pkg::K_ENTER, ertm_pkg::K_LEAVE: begin
                        o_cmd.do_simple = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    priority if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else if (i_stat.track_on) begin
                        n_state = S_BEG;
                    end else begin
                        n_state = S_STATUS;
                    end
                end
            end
            S_BEG: begin
                o_cmd.beg_set = 1'b1;
                if (i_stat.beg_empty) begin
                    n_state = S_STATUS;
                end else begin
                    o_cmd.start_rd0 = 1'b1;
                    n_state = S_BEG1;
                end
            end
            S_BEG1: begin
                o_cmd.cap_cursor = 1'b1;
                o_cmd.start_rd1  = 1'b1;
                n_state = S_BEG2;
            end
            S_BEG2: begin
                o_cmd.cap_run_end = 1'b1;
                n_state = S_STATUS;
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    n_state = S_HASH_A;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_HASH_A: begin
                o_cmd.hash_rd = 1'b1;
                n_state = S_HASH_B;
            end
            S_HASH_B: begin
                o_cmd.hash_chk = 1'b1;
                n_state = i_stat.hash_resolved ? S_DLV : S_HASH_A;
            end
            S_DLV: begin
                if (i_stat.can_deliver) begin
                    o_cmd.rec_rd = 1'b1;
                    n_state = S_DLV_R;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_DLV_R: begin
                if (i_stat.rec_ok) begin
                    o_cmd.stab_rd = 1'b1;
                    n_state = S_DLV_S;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_DLV_S: begin
                if (i_stat.site_match) begin
                    o_cmd.emit_rec = 1'b1;
                    n_state = S_DLV;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                o_cmd.emit_status = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ertm_dpath.sv
// Datapath: track, site and slot memories, run cursor, counters and result registers.
module ertm_dpath #(
    parameter int TRACK_DEPTH    = 4096,
    parameter int INTERVAL_DEPTH = 1024,
    parameter int SITE_DEPTH     = 256,
    parameter int SLOTS          = 1024,
    parameter int SITE_EVENTS    = 8,
    parameter int MAX_RUN        = 63
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ertm_pkg::t_cmd  i_cmd,
    output ertm_pkg::t_stat o_stat,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [10:0]     i_cfg_data,
    input  logic [3:0]      i_kind,
    input  logic [11:0]     i_index,
    input  logic [31:0]     i_fn_key,
    input  logic [15:0]     i_site,
    input  logic [31:0]     i_nth,
    input  logic [7:0]      i_rec_kind,
    input  logic [15:0]     i_ordinal,
    input  logic [31:0]     i_value,
    input  logic signed [3:0] i_event_tag,
    input  logic [12:0]     i_position,
    output logic            o_valid,
    output logic            o_is_record,
    output logic [11:0]     o_interval,
    output logic [7:0]      o_rec_kind_res,
    output logic [15:0]     o_ordinal_res,
    output logic [31:0]     o_value_res,
    output logic            o_last,
    output logic [31:0]     o_placed,
    output logic [31:0]     o_unplaced,
    output logic            o_in_context
);

    localparam int TAW = $clog2(TRACK_DEPTH);
    localparam int CW  = $clog2(TRACK_DEPTH + 1);
    localparam int IAW = $clog2(INTERVAL_DEPTH + 1);
    localparam int SAW = (SITE_DEPTH > 1) ? $clog2(SITE_DEPTH) : 1;
    localparam int SW  = $clog2(SLOTS);
    localparam int EW  = (SITE_EVENTS > 1) ? $clog2(SITE_EVENTS) : 1;
    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int HB  = ertm_pkg::HASH_BITS;
    // rounded-up reciprocal of the slot count, exact for any HB-bit hash
    localparam logic [63:0] RECIP = ((64'd1 << (HB + SW)) + 64'(SLOTS) - 64'd1)
                                    / 64'(SLOTS);

    // latched command
    logic [3:0]  r_kind;
    logic [11:0] r_idx;
    logic [11:0] r_iv;
    logic [31:0] r_key;
    logic [15:0] r_site;
    logic [31:0] r_nth;
    logic [7:0]  r_rkind;
    logic [15:0] r_ord;
    logic [31:0] r_val;
    logic [3:0]  r_tag;
    logic [12:0] r_pos;
    logic        r_by_site;

    // control state
    logic [10:0] r_icount;
    logic [8:0]  r_scount;
    logic [CW-1:0] r_cursor, r_run_end;
    logic [11:0] r_cur_int;
    logic [31:0] r_placed, r_unplaced;
    logic [7:0]  r_ctx;
    logic [31:0] r_hits [SITE_EVENTS];
    logic [SW-1:0] r_clr;
    logic [5:0]  r_n;

    // hash walk
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_probe;
    logic [HB-1:0] r_hbits;
    logic [HB-1:0] r_quot;
    logic [4:0]    r_mod_cnt;
    logic [31:0]   r_seen;

    // memories
    ertm_pkg::t_rec  m_rec  [TRACK_DEPTH];
    logic [12:0]     m_start [INTERVAL_DEPTH + 1];
    ertm_pkg::t_stab m_stab [SITE_DEPTH];
    ertm_pkg::t_slot m_slot [SLOTS];
    ertm_pkg::t_rec  r_rec_q;
    logic [12:0]     r_start_q;
    ertm_pkg::t_stab r_stab_q;
    ertm_pkg::t_slot r_slot_q;

    logic [31:0] idx32, eff_int, eff_sites, hash_full, iv_addr, hit_next, cnt_inc;
    logic        track_on, slot_match, probe_last;
    logic [63:0] mod_prod, mod_rem;
    logic [SW-1:0] slot_next;
    logic        slot_we;
    logic [SW-1:0] slot_wa;
    ertm_pkg::t_slot slot_wd;
    logic [CW-1:0] start_sat;
    logic [EW-1:0] ev_idx;

    assign idx32     = 32'(r_idx);
    assign track_on  = (r_icount != '0);
    assign eff_int   = (32'(r_icount) > 32'(INTERVAL_DEPTH)) ? 32'(INTERVAL_DEPTH)
                                                             : 32'(r_icount);
    assign eff_sites = (32'(r_scount) > 32'(SITE_DEPTH)) ? 32'(SITE_DEPTH) : 32'(r_scount);
    assign hash_full = (i_fn_key >> ertm_pkg::HASH_SHIFT_A)
                     ^ (i_fn_key >> ertm_pkg::HASH_SHIFT_B);
    assign iv_addr   = 32'(r_iv) + (i_cmd.start_rd1 ? 32'd1 : 32'd0);
    assign start_sat = (32'(r_start_q) > 32'(TRACK_DEPTH)) ? CW'(TRACK_DEPTH)
                                                           : CW'(r_start_q);
    assign ev_idx    = r_site[EW-1:0];
    assign hit_next  = r_hits[ev_idx] + 32'd1;
    assign cnt_inc   = r_slot_q.count + 32'd1;
    assign slot_match = (r_slot_q.key == r_key);
    assign probe_last = (r_probe == SW'(SLOTS - 1));
    assign slot_next  = (r_slot == SW'(SLOTS - 1)) ? '0 : r_slot + 1'b1;

    // slot count not a power of two: quotient by reciprocal multiply, then remainder
    assign mod_prod = 64'(r_hbits) * RECIP;
    assign mod_rem  = 64'(r_hbits) - 64'(r_quot) * 64'(SLOTS);

    always_comb begin
        o_stat.kind          = r_kind;
        o_stat.track_on      = track_on;
        o_stat.ctx_zero      = (r_ctx == '0);
        o_stat.run_open      = (r_cursor < r_run_end);
        o_stat.site_ok       = (32'(r_site) < 32'(SITE_EVENTS));
        o_stat.beg_empty     = (32'(r_iv) >= eff_int);
        o_stat.clr_last      = (r_clr == SW'(SLOTS - 1));
        o_stat.mod_done      = (r_mod_cnt == '0);
        o_stat.hash_resolved = !r_slot_q.valid || slot_match || probe_last;
        o_stat.can_deliver   = (r_cursor < r_run_end) && (r_n < 6'(MAX_RUN));
        o_stat.rec_ok        = (32'(r_rec_q.site) < eff_sites) && (r_rec_q.nth == r_seen);
        o_stat.site_match    = r_by_site ? (!r_stab_q.tag[3] &&
                                            (32'(r_stab_q.tag) == 32'(r_site)))
                                         : (r_stab_q.key == r_key);
    end

    always_comb begin
        slot_we = 1'b0;
        slot_wa = r_slot;
        slot_wd = '0;
        if (i_cmd.clr_step) begin
            slot_we = 1'b1;
            slot_wa = r_clr;
        end else if (i_cmd.hash_chk) begin
            if (!r_slot_q.valid) begin
                slot_we = 1'b1;
                slot_wd = '{valid: 1'b1, key: r_key, count: 32'd1};
            end else if (slot_match) begin
                slot_we = 1'b1;
                slot_wd = '{valid: 1'b1, key: r_key, count: cnt_inc};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we)
            m_slot[slot_wa] <= slot_wd;
        if (i_cmd.hash_rd)
            r_slot_q <= m_slot[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && r_kind == ertm_pkg::K_LOAD_REC && idx32 < 32'(TRACK_DEPTH))
            m_rec[idx32[TAW-1:0]] <= '{site: r_site, nth: r_nth, kind: r_rkind,
                                       ordinal: r_ord, value: r_val};
        if (i_cmd.rec_rd)
            r_rec_q <= m_rec[r_cursor[TAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && r_kind == ertm_pkg::K_LOAD_START &&
            idx32 <= 32'(INTERVAL_DEPTH))
            m_start[idx32[IAW-1:0]] <= r_pos;
        if (i_cmd.start_rd0 || i_cmd.start_rd1)
            r_start_q <= m_start[iv_addr[IAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && r_kind == ertm_pkg::K_LOAD_SITE && idx32 < 32'(SITE_DEPTH))
            m_stab[idx32[SAW-1:0]] <= '{tag: r_tag, key: r_key};
        if (i_cmd.stab_rd)
            r_stab_q <= m_stab[r_rec_q.site[SAW-1:0]];
    end

    // latched fields and hash walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind    <= i_kind;
            r_idx     <= i_index;
            r_iv      <= (i_kind == ertm_pkg::K_RESTART) ? 12'd0 : i_index;
            r_key     <= i_fn_key;
            r_site    <= i_site;
            r_nth     <= i_nth;
            r_rkind   <= i_rec_kind;
            r_ord     <= i_ordinal;
            r_val     <= i_value;
            r_tag     <= i_event_tag;
            r_pos     <= i_position;
            r_by_site <= (i_kind == ertm_pkg::K_SITE_EVENT);
            r_hbits   <= hash_full[HB-1:0];
            r_probe   <= '0;
            if (SLOTS_POW2) begin
                r_slot    <= hash_full[SW-1:0];
                r_mod_cnt <= '0;
            end else begin
                r_slot    <= '0;
                r_mod_cnt <= 5'd2;
            end
        end
        if (i_cmd.mod_step) begin
            if (r_mod_cnt == 5'd2)
                r_quot <= HB'(mod_prod >> (HB + SW));
            else
                r_slot <= mod_rem[SW-1:0];
            r_mod_cnt <= r_mod_cnt - 5'd1;
        end
        if (i_cmd.hit_site)
            r_seen <= hit_next;
        if (i_cmd.hash_chk) begin
            priority if (!r_slot_q.valid) begin
                r_seen <= 32'd1;
            end else if (slot_match) begin
                r_seen <= cnt_inc;
            end else begin
                if (probe_last)
                    r_seen <= '0;
                r_slot  <= slot_next;
                r_probe <= r_probe + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icount   <= '0;
            r_scount   <= '0;
            r_cursor   <= '0;
            r_run_end  <= '0;
            r_cur_int  <= ertm_pkg::NO_INTERVAL;
            r_placed   <= '0;
            r_unplaced <= '0;
            r_ctx      <= '0;
            r_clr      <= '0;
            r_n        <= '0;
            o_valid    <= 1'b0;
            for (int i = 0; i < SITE_EVENTS; i++)
                r_hits[i] <= '0;
        end else begin
            o_valid <= i_cmd.emit_rec || i_cmd.emit_status;
            if (i_cfg_we) begin
                if (i_cfg_index == ertm_pkg::CFG_INTERVAL_COUNT)
                    r_icount <= i_cfg_data;
                else
                    r_scount <= i_cfg_data[8:0];
            end
            if (i_cmd.latch)
                r_n <= '0;
            if (i_cmd.clr_begin) begin
                r_clr <= '0;
                for (int i = 0; i < SITE_EVENTS; i++)
                    r_hits[i] <= '0;
            end
            if (i_cmd.clr_step)
                r_clr <= r_clr + 1'b1;
            if (i_cmd.hit_site)
                r_hits[ev_idx] <= hit_next;
            if (i_cmd.restart) begin
                r_cur_int <= ertm_pkg::NO_INTERVAL;
                r_cursor  <= '0;
                r_run_end <= '0;
                if (track_on) begin
                    r_placed   <= '0;
                    r_unplaced <= '0;
                end
            end
            if (i_cmd.do_simple) begin
                unique case (r_kind)
                    ertm_pkg::K_CLOSE: begin
                        if (track_on) begin
                            if (r_run_end > r_cursor)
                                r_unplaced <= r_unplaced + 32'(r_run_end - r_cursor);
                            r_cursor <= r_run_end;
                        end
                    end
                    ertm_pkg::K_ENTER: begin
                        if (r_ctx != ertm_pkg::CTX_MAX)
                            r_ctx <= r_ctx + 8'd1;
                    end
                    ertm_pkg::K_LEAVE: begin
                        if (r_ctx != '0)
                            r_ctx <= r_ctx - 8'd1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.beg_set) begin
                r_cur_int <= r_iv;
                if (o_stat.beg_empty) begin
                    r_cursor  <= '0;
                    r_run_end <= '0;
                end
            end
            if (i_cmd.cap_cursor)
                r_cursor <= start_sat;
            if (i_cmd.cap_run_end)
                r_run_end <= start_sat;
            if (i_cmd.emit_rec) begin
                r_cursor <= r_cursor + 1'b1;
                r_placed <= r_placed + 32'd1;
                r_n      <= r_n + 6'd1;
            end
        end
    end

    // result beat registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rec) begin
            o_is_record    <= 1'b1;
            o_interval     <= r_cur_int;
            o_rec_kind_res <= r_rec_q.kind;
            o_ordinal_res  <= r_rec_q.ordinal;
            o_value_res    <= r_rec_q.value;
            o_last         <= 1'b0;
            o_placed       <= r_placed + 32'd1;
            o_unplaced     <= r_unplaced;
            o_in_context   <= (r_ctx != '0);
        end else if (i_cmd.emit_status) begin
            o_is_record    <= 1'b0;
            o_interval     <= r_cur_int;
            o_rec_kind_res <= '0;
            o_ordinal_res  <= '0;
            o_value_res    <= '0;
            o_last         <= 1'b1;
            o_placed       <= r_placed;
            o_unplaced     <= r_unplaced;
            o_in_context   <= (r_ctx != '0);
        end
    end

endmodule

FILE: src/event_replay_trigger_matcher_unit.sv
// Top level of the event replay trigger matcher.
// Commands enter on i_start while o_busy is low; all fields are sampled on that edge.
// Each command returns zero or more record beats (o_is_record high) followed by one
// status beat (o_last high). Every beat is shown on the result ports for one cycle,
// marked by o_valid; the receiver must take it then, there is no back-pressure.
// Loads, close, enter, leave and unknown kinds go straight from decode to the status
// beat. Restart, and begin while a nonzero interval count is set, sweep the hash slot
// memory, one slot per cycle. An entry event first reduces its hash (unless SLOTS is
// a power of two), then reads and checks the probed slots one at a time; each
// delivered record then takes a record read, a site table read and a check,
// at most MAX_RUN records per command.
// After reset the block is busy while it clears the slot memory;
// configuration writes are taken at any time but belong in idle periods.
// The record, start and site table memories hold no reset value.
module event_replay_trigger_matcher_unit #(
    parameter int TRACK_DEPTH    = 4096,
    parameter int INTERVAL_DEPTH = 1024,
    parameter int SITE_DEPTH     = 256,
    parameter int SLOTS          = 1024,
    parameter int SITE_EVENTS    = 8,
    parameter int MAX_RUN        = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    input  logic [3:0]        i_kind,
    input  logic [11:0]       i_index,
    input  logic [31:0]       i_fn_key,
    input  logic [15:0]       i_site,
    input  logic [31:0]       i_nth,
    input  logic [7:0]        i_rec_kind,
    input  logic [15:0]       i_ordinal,
    input  logic [31:0]       i_value,
    input  logic signed [3:0] i_event_tag,
    input  logic [12:0]       i_position,
    output logic              o_valid,
    output logic              o_is_record,
    output logic [11:0]       o_interval,
    output logic [7:0]        o_rec_kind_res,
    output logic [15:0]       o_ordinal_res,
    output logic [31:0]       o_value_res,
    output logic              o_last,
    output logic [31:0]       o_placed,
    output logic [31:0]       o_unplaced,
    output logic              o_in_context
);

    ertm_pkg::t_cmd  cmd;
    ertm_pkg::t_stat stat;

    ertm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ertm_dpath #(
        .TRACK_DEPTH    (TRACK_DEPTH),
        .INTERVAL_DEPTH (INTERVAL_DEPTH),
        .SITE_DEPTH     (SITE_DEPTH),
        .SLOTS          (SLOTS),
        .SITE_EVENTS    (SITE_EVENTS),
        .MAX_RUN        (MAX_RUN)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_index        (i_index),
        .i_fn_key       (i_fn_key),
        .i_site         (i_site),
        .i_nth          (i_nth),
        .i_rec_kind     (i_rec_kind),
        .i_ordinal      (i_ordinal),
        .i_value        (i_value),
        .i_event_tag    (i_event_tag),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .o_is_record    (o_is_record),
        .o_interval     (o_interval),
        .o_rec_kind_res (o_rec_kind_res),
        .o_ordinal_res  (o_ordinal_res),
        .o_value_res    (o_value_res),
        .o_last         (o_last),
        .o_placed       (o_placed),
        .o_unplaced     (o_unplaced),
        .o_in_context   (o_in_context)
    );

endmodule

FILE: src/ertm_chk.sv
// Port-level checker for the trigger matcher, bound to the top level.
module ertm_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_valid,
    input logic i_is_record,
    input logic i_last
);

    // status beat closes a command and leaves the block idle
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> !i_busy)
        else $error("status beat while busy");

    a_status_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |=> !i_valid)
        else $error("beat right after status beat");

    a_record_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_record |-> i_busy && !i_last)
        else $error("record beat outside a command");

    a_nonlast_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_is_record)
        else $error("status beat without last");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !i_busy |=> i_busy && !i_valid)
        else $error("accepted command did not start");

endmodule

bind event_replay_trigger_matcher_unit ertm_chk u_ertm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .i_busy      (o_busy),
    .i_valid     (o_valid),
    .i_is_record (o_is_record),
    .i_last      (o_last)
);
